/* hdl/dbmh_pkg.sv */
// dbmh_pkg: shared constants and codes for the departure bucket min-heap core
// no dependencies
`default_nettype none
package dbmh_pkg;
  localparam int HEAP_DEPTH_DEF   = 64;
  localparam int BUCKET_SLOTS_DEF = 8;
  localparam int TIME_W = 32;
  localparam int VEH_W  = 16;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_POP   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_HEAP_FULL   = 2'd2,
    ST_BUCKET_FULL = 2'd3
  } status_t;
endpackage
`default_nettype wire

/* hdl/dbmh_ram.sv */
// dbmh_ram: generic single-port-write, single-read ram with registered read
// depends on nothing
`default_nettype none
module dbmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/departure_bucket_min_heap_core.sv */
// Departure bucket min-heap core. Takes one transaction when start is high and
// busy is low. Results appear one per cycle under out_valid; the receiver cannot
// stall them, so every result is taken at the edge that ends its cycle.
// An add or query starts scanning the heap at accept, one entry per cycle, and
// stops at the first equal time or after heap_count entries. An add that hits
// then updates its bucket. An add that misses takes a free bucket and sifts up
// through S_INS_RD and S_INS_CMP for each level visited, new leaf and root
// included. Every add and query then reads the root in S_TOP_RD and drives
// its one result in S_TOP_OUT.
// A pop on an empty heap answers in the cycle after accept and never goes busy.
// Any other pop fetches the root and the last entry in S_POP_RD and S_POP_BKT,
// sends one id per cycle, then sifts down through S_SD_RD, S_SD_CMP1, S_SD_CMP2
// and S_SD_PLACE for each level. It ends with S_SD_RD and S_SD_PLACE when the
// hole has no child left.
// Heap keys, bucket pointers, bucket ids and fill counts live in single-read
// rams, so every step is bounded by one ram read.
`default_nettype none
module departure_bucket_min_heap_core
  #(
  parameter int HEAP_DEPTH   = dbmh_pkg::HEAP_DEPTH_DEF,
  parameter int BUCKET_SLOTS = dbmh_pkg::BUCKET_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [dbmh_pkg::TIME_W-1:0]  in_depart_time,
  input  wire logic [dbmh_pkg::VEH_W-1:0]   in_vehicle_id,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [dbmh_pkg::VEH_W-1:0]        out_out_vehicle,
  output logic [dbmh_pkg::TIME_W-1:0]       out_out_time,
  output logic                              out_last_of_run,
  output logic                              out_waiting,
  output logic [$clog2(HEAP_DEPTH+1)-1:0]   out_entry_count,
  output logic                              out_is_empty
);
  import dbmh_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FW = $clog2(BUCKET_SLOTS + 1);
  localparam int IW = AW + SW;
  localparam int ID_DEPTH = 1 << IW;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_CHK, S_HIT_FILL, S_INS_RD, S_INS_CMP,
    S_POP_RD, S_POP_BKT, S_POP_EMIT, S_SD_RD, S_SD_CMP1, S_SD_CMP2,
    S_SD_PLACE, S_TOP_RD, S_TOP_OUT
  } state_t;

  state_t state_r;
  logic [1:0]        req_r;
  logic [TIME_W-1:0] time_r;
  logic [VEH_W-1:0]  veh_r;
  logic [CW-1:0]     count_r;
  logic [HEAP_DEPTH-1:0] free_r;
  logic [CW-1:0]     idx_r;     // scan index / hole, 1-based
  logic [CW:0]       child_r;
  logic [AW-1:0]     bkt_r;
  logic [FW-1:0]     fill_r;
  logic [FW-1:0]     emit_r;
  logic [TIME_W-1:0] tk_r, ck_r, pt_r;
  logic [AW-1:0]     tb_r, cb_r;
  logic [1:0]        st_r;
  logic              hit_r;

  // ram ports: key+bucket share addresses (heap entry), ids, fills
  logic            h_we;
  logic [AW-1:0]   h_wa, h_ra;
  logic [TIME_W-1:0] hk_wd, hk_rd;
  logic [AW-1:0]   hb_wd, hb_rd;
  logic            i_we;
  logic [IW-1:0]   i_wa, i_ra;
  logic [VEH_W-1:0] i_wd, i_rd;
  logic            f_we;
  logic [AW-1:0]   f_wa, f_ra;
  logic [FW-1:0]   f_wd, f_rd;

  dbmh_ram #(.WIDTH(TIME_W), .DEPTH(HEAP_DEPTH)) u_key (
    .clk, .we(h_we), .waddr(h_wa), .wdata(hk_wd), .raddr(h_ra), .rdata(hk_rd));
  dbmh_ram #(.WIDTH(AW), .DEPTH(HEAP_DEPTH)) u_bkt (
    .clk, .we(h_we), .waddr(h_wa), .wdata(hb_wd), .raddr(h_ra), .rdata(hb_rd));
  dbmh_ram #(.WIDTH(VEH_W), .DEPTH(ID_DEPTH)) u_ids (
    .clk, .we(i_we), .waddr(i_wa), .wdata(i_wd), .raddr(i_ra), .rdata(i_rd));
  dbmh_ram #(.WIDTH(FW), .DEPTH(HEAP_DEPTH)) u_fill (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));

  // lowest free bucket
  logic [AW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = HEAP_DEPTH - 1; i >= 0; i--)
      if (free_r[i]) free_idx = AW'(i);
  end

  function automatic logic [AW-1:0] h2a(input logic [CW:0] h);
    logic [CW:0] t;
    t = h - 1'b1;
    return t[AW-1:0];
  endfunction

  logic [CW:0] parent_w;
  assign parent_w = {1'b0, idx_r} >> 1;

  // right child exists and is smaller than the left one
  logic sd_right;
  assign sd_right = (child_r != {1'b0, count_r}) && (hk_rd < ck_r);

  always_comb begin
    h_we = 1'b0; h_wa = '0; hk_wd = tk_r; hb_wd = tb_r; h_ra = '0;
    i_we = 1'b0; i_wa = '0; i_wd = veh_r; i_ra = '0;
    f_we = 1'b0; f_wa = bkt_r; f_wd = '0; f_ra = bkt_r;
    unique case (state_r)
      S_IDLE:     h_ra = '0;
      S_SCAN_CHK: begin
        // fetch the next entry while this one is compared
        h_ra = idx_r[AW-1:0];
        f_ra = hb_rd;
      end
      S_HIT_FILL: begin
        if (f_rd < FW'(BUCKET_SLOTS)) begin
          i_we = 1'b1; i_wa = {bkt_r, f_rd[SW-1:0]};
          f_we = 1'b1; f_wd = f_rd + 1'b1;
        end
      end
      S_INS_RD: begin
        h_ra = h2a(parent_w);
        // first visit: first id of the new bucket, fill one
        if (idx_r == count_r) begin
          i_we = 1'b1; i_wa = {bkt_r, {SW{1'b0}}};
          f_we = 1'b1; f_wd = FW'(1);
        end
      end
      S_INS_CMP: begin
        h_we = 1'b1; h_wa = h2a({1'b0, idx_r});
        if (idx_r > CW'(1) && tk_r < hk_rd) begin
          hk_wd = hk_rd; hb_wd = hb_rd;
        end
      end
      S_POP_RD: begin
        h_ra = h2a({1'b0, count_r});
        f_ra = hb_rd;
      end
      S_POP_BKT:  i_ra = {bkt_r, {SW{1'b0}}};
      S_POP_EMIT: i_ra = {bkt_r, SW'(emit_r + 1'b1)};
      S_SD_RD:    h_ra = h2a(child_r);
      S_SD_CMP1:  h_ra = h2a(child_r + 1'b1);
      S_SD_CMP2:  ;
      S_SD_PLACE: begin
        h_we = 1'b1; h_wa = h2a({1'b0, idx_r});
        if (!hit_r) begin hk_wd = ck_r; hb_wd = cb_r; end
      end
      S_TOP_RD:   h_ra = '0;
      S_TOP_OUT:  ;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      free_r    <= '1;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          req_r <= in_req_type; time_r <= in_depart_time; veh_r <= in_vehicle_id;
          idx_r <= CW'(1); st_r <= ST_OK; hit_r <= 1'b0;
          unique case (in_req_type)
            REQ_ADD, REQ_QUERY: state_r <= S_SCAN_CHK;
            REQ_POP: begin
              if (count_r == '0) begin
                out_valid <= 1'b1; out_status <= ST_EMPTY; out_out_vehicle <= '0;
                out_out_time <= '0; out_last_of_run <= 1'b1; out_waiting <= 1'b0;
                out_entry_count <= '0; out_is_empty <= 1'b1;
              end else state_r <= S_POP_RD;
            end
            default: state_r <= S_TOP_RD;
          endcase
        end
        S_SCAN_CHK: begin
          // entry idx_r is on the key/bucket read ports
          if (count_r != '0 && hk_rd == time_r) begin
            hit_r <= 1'b1; bkt_r <= hb_rd;
            state_r <= (req_r == REQ_QUERY) ? S_TOP_RD : S_HIT_FILL;
          end else if (count_r != '0 && idx_r < count_r) begin
            idx_r <= idx_r + 1'b1;
          end else if (req_r == REQ_QUERY) begin
            state_r <= S_TOP_RD;
          end else if (count_r == CW'(HEAP_DEPTH)) begin
            st_r <= ST_HEAP_FULL; state_r <= S_TOP_RD;
          end else begin
            bkt_r <= free_idx; free_r[free_idx] <= 1'b0;
            tk_r <= time_r; tb_r <= free_idx;
            count_r <= count_r + 1'b1; idx_r <= count_r + 1'b1;
            state_r <= S_INS_RD;
          end
        end
        S_HIT_FILL: begin
          if (f_rd >= FW'(BUCKET_SLOTS)) st_r <= ST_BUCKET_FULL;
          state_r <= S_TOP_RD;
        end
        S_INS_RD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          if (idx_r > CW'(1) && tk_r < hk_rd) begin
            idx_r <= parent_w[CW-1:0]; state_r <= S_INS_RD;
          end else state_r <= S_TOP_RD;
        end
        S_POP_RD: begin
          // root entry is on the read ports
          pt_r <= hk_rd; bkt_r <= hb_rd; state_r <= S_POP_BKT;
        end
        S_POP_BKT: begin
          // last entry held in tk/tb
          tk_r <= hk_rd; tb_r <= hb_rd;
          fill_r <= (f_rd > FW'(BUCKET_SLOTS)) ? FW'(BUCKET_SLOTS) : f_rd;
          free_r[bkt_r] <= 1'b1; count_r <= count_r - 1'b1;
          emit_r <= '0; state_r <= S_POP_EMIT;
        end
        S_POP_EMIT: begin
          out_valid <= 1'b1; out_status <= ST_OK; out_out_time <= pt_r;
          out_out_vehicle <= (fill_r == '0) ? '0 : i_rd;
          out_waiting <= 1'b0; out_entry_count <= count_r;
          out_is_empty <= (count_r == '0);
          if (fill_r == '0 || emit_r + 1'b1 == fill_r) begin
            out_last_of_run <= 1'b1;
            idx_r <= CW'(1); child_r <= (CW+1)'(2); hit_r <= 1'b1;
            state_r <= (count_r == '0) ? S_IDLE : S_SD_RD;
          end else begin
            out_last_of_run <= 1'b0; emit_r <= emit_r + 1'b1;
          end
        end
        S_SD_RD: begin
          hit_r <= 1'b1;
          state_r <= (child_r <= {1'b0, count_r}) ? S_SD_CMP1 : S_SD_PLACE;
        end
        S_SD_CMP1: begin
          ck_r <= hk_rd; cb_r <= hb_rd; state_r <= S_SD_CMP2;
        end
        S_SD_CMP2: begin
          if (sd_right) begin
            ck_r <= hk_rd; cb_r <= hb_rd; child_r <= child_r + 1'b1;
            hit_r <= !(hk_rd < tk_r);
          end else begin
            hit_r <= !(ck_r < tk_r);
          end
          state_r <= S_SD_PLACE;
        end
        S_SD_PLACE: begin
          if (hit_r) state_r <= S_IDLE;
          else begin
            idx_r <= child_r[CW-1:0]; child_r <= child_r << 1;
            state_r <= S_SD_RD;
          end
        end
        S_TOP_RD: state_r <= S_TOP_OUT;
        S_TOP_OUT: begin
          out_valid <= 1'b1; out_status <= st_r; out_out_vehicle <= '0;
          out_out_time <= (count_r == '0) ? '0 : hk_rd; out_last_of_run <= 1'b1;
          out_waiting <= (req_r == REQ_QUERY) && hit_r;
          out_entry_count <= count_r; out_is_empty <= (count_r == '0);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  property p_busy_when_out_multi;
    @(posedge clk) disable iff (!rst_n) (out_valid && !out_last_of_run) |-> busy;
  endproperty
  a_busy_multi: assert property (p_busy_when_out_multi) else $error("early idle");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0))) else $error("empty flag");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(HEAP_DEPTH)) else $error("count overflow");
endmodule
`default_nettype wire
